### hdl/afs_pkg.sv
// Shared types and constants for the animation frame sequencer.
`default_nettype none

package afs_pkg;

    localparam int ACTION_W = 3;
    localparam int FIELD_W  = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SHOWN_W  = 9;
    localparam int KIND_W   = 2;
    localparam int DELAY_W  = 16;

    // Generation tag stored beside each delay; a match with the current tag means loaded.
    localparam int EPOCH_W  = 8;

    localparam logic [DELAY_W-1:0] DEFAULT_DELAY = 16'd100;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START  = 3'd0,
        ACT_ADD    = 3'd1,
        ACT_FINISH = 3'd2,
        ACT_TICK   = 3'd3,
        ACT_STATIC = 3'd4,
        ACT_CLEAR  = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ARG   = 2'd1,
        ST_BAD_SIZE  = 2'd2,
        ST_BAD_STATE = 2'd3
    } status_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 2'd0,
        KIND_STATIC = 2'd1,
        KIND_ANIM   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        FSM_CLEAR = 2'd0,
        FSM_IDLE  = 2'd1,
        FSM_EXEC  = 2'd2
    } fsm_t;

endpackage

`default_nettype wire

### hdl/afs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module afs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/animation_frame_sequencer_top.sv
// Animation frame sequencer: action decode, per-frame delay memory and playback state.
// An action is accepted in the idle state, which reads the frame memory, and is executed in the
// execute state (write), which waits while the output is stalled; only then is a new action taken.
// Reset: synchronous, active low; afterwards a clearing pass over all MAX_FRAMES entries runs
// before the first action is taken. The same pass follows every 255th action that drops the
// animation (start, set static, clear), when the frame generation tag wraps.
`default_nettype none

module animation_frame_sequencer_top #(
    parameter int MAX_FRAMES = 300
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [afs_pkg::ACTION_W-1:0]   s_action,
    input  wire logic [afs_pkg::FIELD_W-1:0]    s_frame_total,
    input  wire logic [afs_pkg::FIELD_W-1:0]    s_frame_index,
    input  wire logic [afs_pkg::FIELD_W-1:0]    s_frame_delay,
    input  wire logic                           s_data_complete,
    input  wire logic [afs_pkg::TIME_W-1:0]     s_now_ms,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [afs_pkg::STATUS_W-1:0]        m_status,
    output logic                                m_redraw,
    output logic [afs_pkg::SHOWN_W-1:0]         m_shown_frame,
    output logic [afs_pkg::KIND_W-1:0]          m_wallpaper_kind
);

    import afs_pkg::*;

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int MEM_W = EPOCH_W + DELAY_W;

    // Control state.
    fsm_t                 state_reg, state_next;
    logic [IDX_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [CNT_W-1:0]     frames_in_use_reg, frames_in_use_next;
    logic [CNT_W-1:0]     loaded_total_reg, loaded_total_next;
    logic [IDX_W-1:0]     cur_idx_reg, cur_idx_next;
    logic [TIME_W-1:0]    last_change_reg, last_change_next;
    logic                 playing_reg, playing_next;
    kind_t                kind_reg, kind_next;
    logic                 m_valid_reg, m_valid_next;

    // Captured transaction.
    logic [ACTION_W-1:0]  act_reg;
    logic [FIELD_W-1:0]   total_reg;
    logic [FIELD_W-1:0]   index_reg;
    logic [FIELD_W-1:0]   delay_reg;
    logic                 complete_reg;
    logic [TIME_W-1:0]    now_reg;

    // Result payload.
    status_t              status_reg, status_next;
    logic                 redraw_reg, redraw_next;
    logic [SHOWN_W-1:0]   shown_reg;
    kind_t                kind_out_reg;

    // Memory ports.
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [MEM_W-1:0]     wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [MEM_W-1:0]     rd_data;

    logic                 accept;
    logic                 out_free;
    logic                 finish_exec;
    logic                 drop;
    logic                 entry_loaded;
    logic [DELAY_W-1:0]   entry_delay;
    logic [DELAY_W-1:0]   wait_ms;
    logic [TIME_W-1:0]    elapsed;
    logic [CNT_W-1:0]     cur_inc;
    logic [DELAY_W-1:0]   delay_final;

    assign s_ready  = (state_reg == FSM_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish_exec = (state_reg == FSM_EXEC) && out_free;

    assign entry_loaded = (rd_data[MEM_W-1:DELAY_W] == epoch_reg);
    assign entry_delay  = rd_data[DELAY_W-1:0];
    assign wait_ms      = entry_loaded ? entry_delay : '0;
    assign elapsed      = now_reg - last_change_reg;
    assign cur_inc      = CNT_W'(cur_idx_reg) + CNT_W'(1);
    assign delay_final  = (delay_reg != '0) ? delay_reg : DEFAULT_DELAY;

    // Delay memory: each word holds the generation tag and the frame delay.
    afs_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_FRAMES)
    ) u_delay_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_CLEAR: begin
                if (clr_addr_reg == IDX_W'(MAX_FRAMES - 1)) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                if (s_valid) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (out_free) begin
                    state_next = (drop && (epoch_reg == '1)) ? FSM_CLEAR : FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Action execution, memory access and result formation.
    always_comb begin
        clr_addr_next      = clr_addr_reg;
        epoch_next         = epoch_reg;
        frames_in_use_next = frames_in_use_reg;
        loaded_total_next  = loaded_total_reg;
        cur_idx_next       = cur_idx_reg;
        last_change_next   = last_change_reg;
        playing_next       = playing_reg;
        kind_next          = kind_reg;
        status_next        = ST_OK;
        redraw_next        = 1'b0;
        drop               = 1'b0;
        m_valid_next       = m_valid_reg && !m_ready;

        rd_en   = accept;
        rd_addr = (s_action == ACT_ADD) ? s_frame_index[IDX_W-1:0] : cur_idx_reg;
        wr_en   = 1'b0;
        wr_addr = index_reg[IDX_W-1:0];
        wr_data = {epoch_reg, delay_final};

        // The clearing pass writes a tag that never matches a live generation.
        if (state_reg == FSM_CLEAR) begin
            wr_en         = 1'b1;
            wr_addr       = clr_addr_reg;
            wr_data       = '0;
            clr_addr_next = clr_addr_reg + IDX_W'(1);
        end

        if (finish_exec) begin
            m_valid_next = 1'b1;
            case (act_reg)
                ACT_START: begin
                    if ((total_reg == '0) || (total_reg > FIELD_W'(MAX_FRAMES))) begin
                        status_next = ST_BAD_ARG;
                    end else begin
                        drop = 1'b1;
                    end
                end
                ACT_ADD: begin
                    if ((frames_in_use_reg == '0) ||
                        (index_reg >= FIELD_W'(frames_in_use_reg))) begin
                        status_next = ST_BAD_ARG;
                    end else if (!complete_reg) begin
                        status_next = ST_BAD_SIZE;
                    end else begin
                        wr_en = 1'b1;
                        if (!entry_loaded) begin
                            loaded_total_next = loaded_total_reg + CNT_W'(1);
                        end
                    end
                end
                ACT_FINISH: begin
                    if ((frames_in_use_reg == '0) || (loaded_total_reg == '0)) begin
                        status_next = ST_BAD_STATE;
                    end else begin
                        kind_next        = KIND_ANIM;
                        cur_idx_next     = '0;
                        last_change_next = now_reg;
                        playing_next     = 1'b1;
                    end
                end
                ACT_TICK: begin
                    if ((kind_reg == KIND_ANIM) && playing_reg && (frames_in_use_reg != '0) &&
                        (elapsed >= TIME_W'(wait_ms))) begin
                        cur_idx_next     = (cur_inc == frames_in_use_reg) ? '0
                                                                          : IDX_W'(cur_inc);
                        last_change_next = now_reg;
                        redraw_next      = 1'b1;
                    end
                end
                ACT_STATIC: begin
                    if (!complete_reg) begin
                        status_next = ST_BAD_SIZE;
                    end else begin
                        drop      = 1'b1;
                        kind_next = KIND_STATIC;
                    end
                end
                ACT_CLEAR: begin
                    drop      = 1'b1;
                    kind_next = KIND_NONE;
                end
                default: begin
                    status_next = ST_BAD_ARG;
                end
            endcase

            // Dropping the animation retires the current generation of loaded marks.
            if (drop) begin
                frames_in_use_next = '0;
                loaded_total_next  = '0;
                cur_idx_next       = '0;
                playing_next       = 1'b0;
                if (epoch_reg == '1) begin
                    epoch_next    = EPOCH_W'(1);
                    clr_addr_next = '0;
                end else begin
                    epoch_next = epoch_reg + EPOCH_W'(1);
                end
            end

            if ((act_reg == ACT_START) && drop) begin
                frames_in_use_next = CNT_W'(total_reg);
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= FSM_CLEAR;
            clr_addr_reg      <= '0;
            epoch_reg         <= EPOCH_W'(1);
            frames_in_use_reg <= '0;
            loaded_total_reg  <= '0;
            cur_idx_reg       <= '0;
            last_change_reg   <= '0;
            playing_reg       <= 1'b0;
            kind_reg          <= KIND_STATIC;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            clr_addr_reg      <= clr_addr_next;
            epoch_reg         <= epoch_next;
            frames_in_use_reg <= frames_in_use_next;
            loaded_total_reg  <= loaded_total_next;
            cur_idx_reg       <= cur_idx_next;
            last_change_reg   <= last_change_next;
            playing_reg       <= playing_next;
            kind_reg          <= kind_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // Transaction capture.
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg      <= s_action;
            total_reg    <= s_frame_total;
            index_reg    <= s_frame_index;
            delay_reg    <= s_frame_delay;
            complete_reg <= s_data_complete;
            now_reg      <= s_now_ms;
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        if (finish_exec) begin
            status_reg   <= status_next;
            redraw_reg   <= redraw_next;
            shown_reg    <= SHOWN_W'(cur_idx_next);
            kind_out_reg <= kind_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_redraw         = redraw_reg;
    assign m_shown_frame    = shown_reg;
    assign m_wallpaper_kind = kind_out_reg;

endmodule

`default_nettype wire

### hdl/afs_checker.sv
// Port-level checks for the animation frame sequencer and their binding to the top level.
`default_nettype none

module afs_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic [afs_pkg::ACTION_W-1:0]   s_action,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [afs_pkg::STATUS_W-1:0]   m_status,
    input wire logic                           m_redraw,
    input wire logic [afs_pkg::KIND_W-1:0]     m_wallpaper_kind
);

    import afs_pkg::*;

    // A stalled result keeps its content.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_redraw))
        else $error("result changed while stalled");

    // Only one action is in flight: no accept in the cycle after an accept.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted while one is executing");

    // A redraw only comes from a successful tick on an animated wallpaper.
    a_redraw_anim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_redraw |-> (m_status == ST_OK) && (m_wallpaper_kind == KIND_ANIM))
        else $error("redraw without animated wallpaper");

    // A clear always succeeds and leaves no wallpaper.
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == ACT_CLEAR) && !m_valid |=> ##1
        m_valid && (m_status == ST_OK) && (m_wallpaper_kind == KIND_NONE))
        else $error("clear did not report an empty wallpaper");

endmodule

bind animation_frame_sequencer_top afs_checker u_afs_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_action         (s_action),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_redraw         (m_redraw),
    .m_wallpaper_kind (m_wallpaper_kind)
);

`default_nettype wire

### dv/tb_animation_frame_sequencer_top.sv
// Self-checking testbench for the animation frame sequencer: random and directed actions.
`timescale 1ns / 1ps

import afs_pkg::*;

localparam int FRAME_CAP = 300;

// Action codes that the block must reject.
localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

typedef struct {
    logic [ACTION_W-1:0] act;
    logic [FIELD_W-1:0]  total;
    logic [FIELD_W-1:0]  index;
    logic [FIELD_W-1:0]  delay;
    logic                complete;
    logic [TIME_W-1:0]   now;
} wallpaper_cmd_t;

typedef struct {
    logic [STATUS_W-1:0] status;
    logic                redraw;
    logic [SHOWN_W-1:0]  shown;
    logic [KIND_W-1:0]   kind;
} wallpaper_view_t;

// Mirrors the sequencer state and holds the views still owed by the block.
class frame_sequence_checker;
    wallpaper_view_t expected_views[$];
    int errors;

    logic [DELAY_W-1:0] delay_mem [FRAME_CAP];
    bit                 loaded [FRAME_CAP];
    logic [SHOWN_W-1:0] frames_open;
    logic [SHOWN_W-1:0] loaded_count;
    logic [SHOWN_W-1:0] cur_frame;
    logic [TIME_W-1:0]  last_ms;
    bit                 playing;
    kind_t              wp_kind;

    function new();
        errors = 0;
        foreach (delay_mem[i]) delay_mem[i] = '0;
        drop_animation();
        last_ms = '0;
        wp_kind = KIND_STATIC;
    endfunction

    function void drop_animation();
        foreach (loaded[i]) loaded[i] = 1'b0;
        frames_open  = '0;
        loaded_count = '0;
        cur_frame    = '0;
        playing      = 1'b0;
    endfunction

    function int pending();
        return expected_views.size();
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endfunction

    // Apply one accepted transaction to the mirrored state and queue the resulting view.
    function void note_command(wallpaper_cmd_t cmd);
        wallpaper_view_t    v;
        logic [DELAY_W-1:0] hold_ms;
        logic [TIME_W-1:0]  elapsed;
        v.status = ST_OK;
        v.redraw = 1'b0;
        case (cmd.act)
            ACT_START: begin
                if (cmd.total == 0 || cmd.total > FRAME_CAP) begin
                    v.status = ST_BAD_ARG;
                end else begin
                    drop_animation();
                    frames_open = cmd.total[SHOWN_W-1:0];
                end
            end
            ACT_ADD: begin
                if (frames_open == 0 || cmd.index >= frames_open || cmd.index >= FRAME_CAP) begin
                    v.status = ST_BAD_ARG;
                end else if (!cmd.complete) begin
                    v.status = ST_BAD_SIZE;
                end else begin
                    delay_mem[cmd.index] = (cmd.delay != 0) ? cmd.delay : DEFAULT_DELAY;
                    if (!loaded[cmd.index]) begin
                        loaded[cmd.index] = 1'b1;
                        loaded_count++;
                    end
                end
            end
            ACT_FINISH: begin
                if (frames_open == 0 || loaded_count == 0) begin
                    v.status = ST_BAD_STATE;
                end else begin
                    wp_kind   = KIND_ANIM;
                    cur_frame = '0;
                    last_ms   = cmd.now;
                    playing   = 1'b1;
                end
            end
            ACT_TICK: begin
                // An unloaded frame has no hold time, so it is skipped on the next tick.
                if (wp_kind == KIND_ANIM && playing && frames_open != 0 && cur_frame < FRAME_CAP) begin
                    hold_ms = loaded[cur_frame] ? delay_mem[cur_frame] : '0;
                    elapsed = cmd.now - last_ms;
                    if (elapsed >= hold_ms) begin
                        cur_frame = SHOWN_W'((cur_frame + 1) % frames_open);
                        last_ms   = cmd.now;
                        v.redraw  = 1'b1;
                    end
                end
            end
            ACT_STATIC: begin
                if (!cmd.complete) begin
                    v.status = ST_BAD_SIZE;
                end else begin
                    drop_animation();
                    wp_kind = KIND_STATIC;
                end
            end
            ACT_CLEAR: begin
                drop_animation();
                wp_kind = KIND_NONE;
            end
            default: begin
                v.status = ST_BAD_ARG;
            end
        endcase
        v.shown = cur_frame;
        v.kind  = wp_kind;
        expected_views.push_back(v);
    endfunction

    // Compare one accepted result with the oldest queued view.
    function void check_view(wallpaper_view_t got);
        wallpaper_view_t want;
        if (expected_views.size() == 0) begin
            report("result with nothing outstanding, status", 32'(got.status), 32'd0);
            return;
        end
        want = expected_views.pop_front();
        if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
        if (got.redraw !== want.redraw) report("redraw", 32'(got.redraw), 32'(want.redraw));
        if (got.shown !== want.shown) report("shown_frame", 32'(got.shown), 32'(want.shown));
        if (got.kind !== want.kind) report("wallpaper_kind", 32'(got.kind), 32'(want.kind));
    endfunction
endclass

module tb_animation_frame_sequencer_top;

    localparam int STALL_LIMIT = 4000;

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action        = '0;
    logic [FIELD_W-1:0]  s_frame_total   = '0;
    logic [FIELD_W-1:0]  s_frame_index   = '0;
    logic [FIELD_W-1:0]  s_frame_delay   = '0;
    logic                s_data_complete = 1'b0;
    logic [TIME_W-1:0]   s_now_ms        = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic                m_redraw;
    logic [SHOWN_W-1:0]  m_shown_frame;
    logic [KIND_W-1:0]   m_wallpaper_kind;

    frame_sequence_checker checker_h = new();

    int                actions_issued = 0;
    int                burst_left     = 0;
    int                idle_cycles    = 0;
    logic [9:0]        rx_cycle       = '0;
    logic [TIME_W-1:0] clock_ms       = 32'hFFFF_F000;

    animation_frame_sequencer_top #(
        .MAX_FRAMES(FRAME_CAP)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_frame_total   (s_frame_total),
        .s_frame_index   (s_frame_index),
        .s_frame_delay   (s_frame_delay),
        .s_data_complete (s_data_complete),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_redraw        (m_redraw),
        .m_shown_frame   (m_shown_frame),
        .m_wallpaper_kind(m_wallpaper_kind)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    // Offer one action, after a random idle gap (possibly none) when the current burst is used up.
    task automatic issue_action(input logic [ACTION_W-1:0] act, input logic [FIELD_W-1:0] total,
                                input logic [FIELD_W-1:0] index, input logic [FIELD_W-1:0] delay,
                                input logic complete, input logic [TIME_W-1:0] now);
        wallpaper_cmd_t cmd;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid         <= 1'b0;
                s_action        <= 3'($urandom);
                s_frame_total   <= rand16();
                s_frame_index   <= rand16();
                s_frame_delay   <= rand16();
                s_data_complete <= 1'($urandom);
                s_now_ms        <= $urandom;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        cmd.act      = act;
        cmd.total    = total;
        cmd.index    = index;
        cmd.delay    = delay;
        cmd.complete = complete;
        cmd.now      = now;
        s_valid         <= 1'b1;
        s_action        <= act;
        s_frame_total   <= total;
        s_frame_index   <= index;
        s_frame_delay   <= delay;
        s_data_complete <= complete;
        s_now_ms        <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        checker_h.note_command(cmd);
        actions_issued++;
    endtask

    // Tick with the playback clock moved forward by a random step.
    task automatic tick_forward(input int max_step);
        if ($urandom_range(0, 15) == 0) clock_ms = clock_ms + $urandom;
        else clock_ms = clock_ms + $urandom_range(0, max_step);
        issue_action(ACT_TICK, rand16(), rand16(), rand16(), 1'($urandom), clock_ms);
    endtask

    // Result side: check each transaction and stall on a pattern chosen by bits 8:7 of the cycle counter.
    always @(posedge aclk) begin
        wallpaper_view_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status = m_status;
            got.redraw = m_redraw;
            got.shown  = m_shown_frame;
            got.kind   = m_wallpaper_kind;
            checker_h.check_view(got);
        end
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[8:7])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            2'd2: m_ready <= (rx_cycle[2:0] == 3'd0);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog on cycles without any transaction on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int n;
        int steps;
        logic [FIELD_W-1:0] idx;
        logic [FIELD_W-1:0] dly;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: idle tick, rejects before any animation, bad totals and spare actions.
        issue_action(ACT_TICK, rand16(), rand16(), rand16(), 1'b1, 32'h0);
        issue_action(ACT_FINISH, rand16(), rand16(), rand16(), 1'b1, 32'h0);
        issue_action(ACT_ADD, rand16(), 16'd0, 16'd5, 1'b1, 32'h0);
        issue_action(ACT_START, 16'd0, rand16(), rand16(), 1'b1, 32'h0);
        issue_action(ACT_START, 16'(FRAME_CAP + 1), rand16(), rand16(), 1'b1, 32'h0);
        issue_action(ACT_START, 16'hFFFF, rand16(), rand16(), 1'b0, 32'hFFFF_FFFF);
        issue_action(ACT_SPARE_A, rand16(), rand16(), rand16(), 1'b1, 32'h0);
        issue_action(ACT_SPARE_B, rand16(), rand16(), rand16(), 1'b0, 32'h0);
        // Largest animation: last index accepted with the default delay, one past it rejected.
        issue_action(ACT_START, 16'(FRAME_CAP), rand16(), rand16(), 1'b1, 32'h0);
        issue_action(ACT_ADD, rand16(), 16'(FRAME_CAP - 1), 16'd0, 1'b1, 32'h0);
        issue_action(ACT_ADD, rand16(), 16'(FRAME_CAP), 16'd7, 1'b1, 32'h0);
        issue_action(ACT_ADD, rand16(), 16'hFFFF, 16'hFFFF, 1'b1, 32'h0);
        // Restart forgets loaded frames; finish then has nothing to play.
        issue_action(ACT_START, 16'd3, rand16(), rand16(), 1'b1, 32'h0);
        issue_action(ACT_FINISH, rand16(), rand16(), rand16(), 1'b1, 32'h0);
        issue_action(ACT_ADD, rand16(), 16'd0, 16'd5, 1'b0, 32'h0);
        // Re-adding a frame overwrites its delay without counting it twice.
        issue_action(ACT_ADD, rand16(), 16'd0, 16'd5, 1'b1, 32'h0);
        issue_action(ACT_ADD, rand16(), 16'd0, 16'hFFFF, 1'b1, 32'h0);
        issue_action(ACT_ADD, rand16(), 16'd0, 16'd2, 1'b1, 32'h0);
        issue_action(ACT_ADD, rand16(), 16'd2, 16'd0, 1'b1, 32'h0);
        // Playback across the timestamp wrap; frame 1 is unloaded and skipped at once.
        issue_action(ACT_FINISH, rand16(), rand16(), rand16(), 1'b1, 32'hFFFF_FFFE);
        issue_action(ACT_TICK, rand16(), rand16(), rand16(), 1'b1, 32'hFFFF_FFFF);
        issue_action(ACT_TICK, rand16(), rand16(), rand16(), 1'b1, 32'h0);
        issue_action(ACT_TICK, rand16(), rand16(), rand16(), 1'b1, 32'h0);
        issue_action(ACT_TICK, rand16(), rand16(), rand16(), 1'b1, 32'd50);
        issue_action(ACT_TICK, rand16(), rand16(), rand16(), 1'b1, 32'd100);
        // Static image with and without full data, then clear and the idle checks after it.
        issue_action(ACT_STATIC, rand16(), rand16(), rand16(), 1'b0, 32'h0);
        issue_action(ACT_STATIC, rand16(), rand16(), rand16(), 1'b1, 32'h0);
        issue_action(ACT_CLEAR, rand16(), rand16(), rand16(), 1'b0, 32'h0);
        issue_action(ACT_TICK, rand16(), rand16(), rand16(), 1'b1, 32'hFFFF_FFFF);

        // One long animation so that playback walks through every frame index.
        n = $urandom_range(FRAME_CAP - 10, FRAME_CAP);
        issue_action(ACT_START, 16'(n), rand16(), rand16(), 1'b1, $urandom);
        for (int k = 0; k < 6; k++) begin
            idx = (k == 0) ? 16'(n - 1) : 16'($urandom_range(0, n - 1));
            issue_action(ACT_ADD, rand16(), idx, 16'($urandom_range(0, 60)), 1'b1, $urandom);
        end
        issue_action(ACT_FINISH, rand16(), rand16(), rand16(), 1'b1, clock_ms);
        for (int k = 0; k < n + 20; k++) tick_forward(120);

        // Random part: mostly complete animation sequences, the rest noise and stray actions.
        while (actions_issued < 400) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
                    n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, FRAME_CAP)
                                                     : $urandom_range(1, 8);
                    issue_action(ACT_START, 16'(n), rand16(), rand16(), 1'($urandom), $urandom);
                    steps = $urandom_range(1, (n < 8) ? n + 2 : 10);
                    for (int k = 0; k < steps; k++) begin
                        idx = ($urandom_range(0, 9) == 0) ? rand16() : 16'($urandom_range(0, n - 1));
                        dly = ($urandom_range(0, 7) == 0) ? rand16() : 16'($urandom_range(0, 40));
                        issue_action(ACT_ADD, rand16(), idx, dly, ($urandom_range(0, 9) != 0),
                                     $urandom);
                    end
                    clock_ms = clock_ms + $urandom_range(0, 50);
                    issue_action(ACT_FINISH, rand16(), rand16(), rand16(), 1'($urandom), clock_ms);
                    steps = $urandom_range(2, 24);
                    for (int k = 0; k < steps; k++) begin
                        if ($urandom_range(0, 9) == 0) begin
                            issue_action(ACT_ADD, rand16(), 16'($urandom_range(0, n - 1)),
                                         16'($urandom_range(0, 40)), 1'b1, $urandom);
                        end
                        tick_forward(30);
                    end
                end
                10, 11: begin
                    issue_action(3'($urandom_range(0, 7)), rand16(), rand16(), rand16(),
                                 1'($urandom), $urandom);
                end
                12: begin
                    issue_action(ACT_START, $urandom_range(0, 1) ? 16'd0
                                 : 16'($urandom_range(FRAME_CAP + 1, 65535)),
                                 rand16(), rand16(), 1'($urandom), $urandom);
                end
                13: begin
                    issue_action(ACT_STATIC, rand16(), rand16(), rand16(), 1'($urandom), $urandom);
                end
                14: begin
                    issue_action(ACT_CLEAR, rand16(), rand16(), rand16(), 1'($urandom), $urandom);
                end
                default: begin
                    issue_action(ACT_FINISH, rand16(), rand16(), rand16(), 1'($urandom), $urandom);
                    tick_forward(200);
                end
            endcase
        end

        // Drain the outstanding results, then let any stray result appear before the verdict.
        s_valid <= 1'b0;
        while (checker_h.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (checker_h.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/afs_pkg.sv
hdl/afs_ram.sv
hdl/animation_frame_sequencer_top.sv
hdl/afs_checker.sv
dv/tb_animation_frame_sequencer_top.sv
